### rtl/core/lcs_pkg.sv
`default_nettype none
package lcs_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int DATA_W = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int USER_W = 2;
  localparam int CNT_W = (PIXEL_BITS > 2) ? $clog2(PIXEL_BITS) : 1;

  // tuser bit positions
  localparam int USER_ACTION = 0;
  localparam int USER_START = 1;

  // action codes
  localparam logic ACT_MEASURE = 1'b0;
  localparam logic ACT_NORMALIZE = 1'b1;

  localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = '1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_PUT
  } state_t;

  typedef struct packed {
    logic measure;  // fold pixel into min/max
    logic capture;  // latch clamped offset and span
    logic load;     // form numerator, seed remainder
    logic step;     // one restoring-division step
    logic put;      // move quotient to output register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a new result
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/lcs_ctrl.sv
`default_nettype none
module lcs_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         action,
  output logic              in_ready,
  input  wire lcs_pkg::sts_t sts,
  output lcs_pkg::cmd_t     cmd
);
  import lcs_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_NORMALIZE) begin
            cmd.capture = 1'b1;
            state_next = S_LOAD;
          end else begin
            cmd.measure = 1'b1;
          end
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        cnt_next = CNT_W'(PIXEL_BITS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          state_next = S_PUT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.put = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_put_free: assert property (@(posedge clk) disable iff (rst)
    cmd.put |-> sts.out_free)
    else $error("result moved into a full output register");

  a_norm_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_NORMALIZE) |=> state == S_LOAD)
    else $error("normalize request did not start a division");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == '0) |=> state == S_PUT)
    else $error("division did not end after the last step");

endmodule
`default_nettype wire

### rtl/core/lcs_dp.sv
`default_nettype none
module lcs_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lcs_pkg::pixel_t pixel,
  input  wire logic           frame_start,
  input  wire logic           out_ready,
  input  wire lcs_pkg::cmd_t  cmd,
  output lcs_pkg::sts_t       sts,
  output lcs_pkg::pixel_t     out_pixel,
  output logic                out_valid
);
  import lcs_pkg::*;

  pixel_t min_level, max_level;
  pixel_t diff, den, rem, shreg, clamped;
  logic flat;
  logic [2*PIXEL_BITS-1:0] num;
  logic [PIXEL_BITS:0] rem_sh, den_x;
  logic ge;

  always_comb begin
    if (pixel < min_level) begin
      clamped = min_level;
    end else if (pixel > max_level) begin
      clamped = max_level;
    end else begin
      clamped = pixel;
    end
  end

  // diff * (2^P - 1) as a shift and subtract
  assign num = {diff, {PIXEL_BITS{1'b0}}} - {{PIXEL_BITS{1'b0}}, diff};
  assign rem_sh = {rem, shreg[PIXEL_BITS-1]};
  assign den_x = {1'b0, den};
  assign ge = (rem_sh >= den_x);

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= PIXEL_MAX;
      max_level <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.measure) begin
        if (frame_start) begin
          min_level <= pixel;
          max_level <= pixel;
        end else begin
          if (pixel < min_level) min_level <= pixel;
          if (pixel > max_level) max_level <= pixel;
        end
      end
      if (cmd.put) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff <= clamped - min_level;
      den <= max_level - min_level;
      flat <= (max_level <= min_level);
    end
    if (cmd.load) begin
      rem <= num[2*PIXEL_BITS-1:PIXEL_BITS];
      shreg <= num[PIXEL_BITS-1:0];
    end
    if (cmd.step) begin
      rem <= ge ? PIXEL_BITS'(rem_sh - den_x) : rem_sh[PIXEL_BITS-1:0];
      shreg <= {shreg[PIXEL_BITS-2:0], ge};
    end
    if (cmd.put) begin
      out_pixel <= flat ? '0 : shreg;
    end
  end

  a_hold_levels: assert property (@(posedge clk) disable iff (rst)
    !cmd.measure |=> ($stable(min_level) && $stable(max_level)))
    else $error("levels changed outside a measure request");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !flat) |-> (rem < den))
    else $error("division remainder not below divisor");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.put && flat) |=> (out_pixel == '0))
    else $error("flat frame gave a nonzero result");

endmodule
`default_nettype wire

### rtl/core/linear_contrast_stretch.sv
`default_nettype none
// Channel  Dir  Signals                          Contents
// s_axis   in   tvalid tready tdata tuser        tdata: pixel; tuser: action, frame_start
// m_axis   out  tvalid tready tdata              tdata: scaled_pixel
//
// Measure requests (action 0) are folded into min/max as taken and give no result.
// Normalize requests (action 1) run through capture, numerator load,
// one restoring-division step per quotient bit, then a move into the
// output register; no new request is taken until the move is done.
// Reset (rst, synchronous) sets min to all ones, max to zero, drops m_axis_tvalid.
// A result waiting on m_axis does not block measure requests; a normalize
// request waits only at its end for the output register to free up.
module linear_contrast_stretch (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [lcs_pkg::DATA_W-1:0] s_axis_tdata,  // [7:0] pixel
  input  wire logic [lcs_pkg::USER_W-1:0] s_axis_tuser,  // [0] action, [1] frame_start
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [lcs_pkg::DATA_W-1:0]      m_axis_tdata   // [7:0] scaled_pixel
);
  import lcs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  pixel_t out_pixel;

  lcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .action   (s_axis_tuser[USER_ACTION]),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .pixel       (s_axis_tdata[PIXEL_BITS-1:0]),
    .frame_start (s_axis_tuser[USER_START]),
    .out_ready   (m_axis_tready),
    .cmd         (cmd),
    .sts         (sts),
    .out_pixel   (out_pixel),
    .out_valid   (m_axis_tvalid)
  );

  // pad result up to whole bytes
  assign m_axis_tdata = DATA_W'(out_pixel);

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

// Scoreboard for the min/max contrast stretch: mirrors the measured range
// and keeps the scaled levels still owed by the block, oldest first.
class stretch_scoreboard;
  lcs_pkg::pixel_t min_level;
  lcs_pkg::pixel_t max_level;
  lcs_pkg::pixel_t expected_levels[$];
  int              errors;

  function new();
    min_level = lcs_pkg::PIXEL_MAX;
    max_level = '0;
    errors    = 0;
  endfunction

  // floor((clamped - min) * PIXEL_MAX / (max - min)); flat or unmeasured range gives 0
  function lcs_pkg::pixel_t stretched_level(lcs_pkg::pixel_t p);
    lcs_pkg::pixel_t                   clamped;
    logic [2*lcs_pkg::PIXEL_BITS-1:0]  offset;
    logic [2*lcs_pkg::PIXEL_BITS-1:0]  span;
    logic [2*lcs_pkg::PIXEL_BITS-1:0]  product;
    if (max_level <= min_level) return '0;
    clamped = (p < min_level) ? min_level : (p > max_level) ? max_level : p;
    offset  = clamped - min_level;
    span    = max_level - min_level;
    product = offset * lcs_pkg::PIXEL_MAX;
    return lcs_pkg::pixel_t'(product / span);
  endfunction

  function void note_request(logic act, lcs_pkg::pixel_t px, logic fs);
    if (act == lcs_pkg::ACT_MEASURE) begin
      if (fs) begin
        min_level = px;
        max_level = px;
      end else begin
        if (px < min_level) min_level = px;
        if (px > max_level) max_level = px;
      end
    end else begin
      // frame_start is ignored in the normalize pass
      expected_levels.push_back(stretched_level(px));
    end
  endfunction

  function void check_result(logic [lcs_pkg::DATA_W-1:0] data);
    lcs_pkg::pixel_t want;
    if (expected_levels.size() == 0) begin
      $display("%0t: unexpected result scaled_pixel=%0d", $time,
               data[lcs_pkg::PIXEL_BITS-1:0]);
      errors++;
      return;
    end
    want = expected_levels.pop_front();
    if (data[lcs_pkg::PIXEL_BITS-1:0] !== want) begin
      $display("%0t: scaled_pixel mismatch: expected %0d, got %0d", $time, want,
               data[lcs_pkg::PIXEL_BITS-1:0]);
      errors++;
    end
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction
endclass

module testbench;
  import lcs_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_ITEMS  = 125;
  localparam int DRAIN_CYCLES = 4000;
  localparam int TAIL_CYCLES  = 2 * (PIXEL_BITS + 3);

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata;
  logic [USER_W-1:0] s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [DATA_W-1:0] m_axis_tdata;

  stretch_scoreboard tracker;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                sent_count;

  linear_contrast_stretch uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Called just after a falling edge; returns just after the falling edge
  // following acceptance, so back-to-back requests keep tvalid high.
  task automatic send_request(input logic act, input pixel_t px, input logic fs);
    logic [USER_W-1:0] user;
    int                gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = DATA_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    user               = '0;
    user[USER_ACTION]  = act;
    user[USER_START]   = fs;
    s_axis_tvalid      = 1'b1;
    s_axis_tdata       = DATA_W'(px);
    s_axis_tuser       = user;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_request(act, px, fs);
    sent_count++;
    @(negedge clk);
  endtask

  // One frame: measure pass then normalize pass over the same pixels.
  // Some frames are broken on purpose (stray or missing frame_start), and
  // some normalize pixels are swapped for random values.
  task automatic send_frame();
    pixel_t frame_px[$];
    int     n;
    int     shape;
    int     base;
    int     spread;
    logic   broken;
    logic   fs;
    pixel_t px;
    n      = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
    shape  = $urandom_range(3);
    base   = $urandom_range(PIXEL_MAX);
    spread = (shape == 1) ? $urandom_range(1, 15) : 0;
    broken = ($urandom_range(99) < 15);
    for (int i = 0; i < n; i++) begin
      case (shape)
        1: px = ((base + spread) > PIXEL_MAX) ? pixel_t'(PIXEL_MAX - $urandom_range(spread))
                                              : pixel_t'(base + $urandom_range(spread));
        2: px = pixel_t'(base);
        default: px = pixel_t'($urandom);
      endcase
      frame_px.push_back(px);
    end
    for (int i = 0; i < n; i++) begin
      fs = (i == 0);
      if (broken) fs = 1'($urandom_range(1));
      send_request(ACT_MEASURE, frame_px[i], fs);
    end
    for (int i = 0; i < n; i++) begin
      px = frame_px[i];
      if ($urandom_range(99) < 20) px = pixel_t'($urandom);
      send_request(ACT_NORMALIZE, px, 1'($urandom_range(1)));
    end
  endtask

  // receiver: ready decided at each falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int waited;
    tracker        = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    sent_count     = 0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // unmeasured range right after reset -> 0, frame_start ignored
    send_request(ACT_NORMALIZE, '0, 1'b0);
    send_request(ACT_NORMALIZE, PIXEL_MAX, 1'b1);
    send_request(ACT_NORMALIZE, pixel_t'(128), 1'b0);
    // measured range 10..200, clamping below and above
    send_request(ACT_MEASURE, pixel_t'(50), 1'b1);
    send_request(ACT_MEASURE, pixel_t'(200), 1'b0);
    send_request(ACT_MEASURE, pixel_t'(10), 1'b0);
    send_request(ACT_NORMALIZE, '0, 1'b0);
    send_request(ACT_NORMALIZE, pixel_t'(10), 1'b0);
    send_request(ACT_NORMALIZE, pixel_t'(100), 1'b1);
    send_request(ACT_NORMALIZE, pixel_t'(200), 1'b0);
    send_request(ACT_NORMALIZE, PIXEL_MAX, 1'b0);
    // measure without frame_start keeps widening the old range
    send_request(ACT_MEASURE, PIXEL_MAX, 1'b0);
    send_request(ACT_NORMALIZE, pixel_t'(254), 1'b0);
    // flat frame -> 0
    send_request(ACT_MEASURE, pixel_t'(77), 1'b1);
    send_request(ACT_MEASURE, pixel_t'(77), 1'b0);
    send_request(ACT_NORMALIZE, pixel_t'(77), 1'b0);
    send_request(ACT_NORMALIZE, '0, 1'b0);
    send_request(ACT_NORMALIZE, PIXEL_MAX, 1'b0);
    // full range, start on the extremes
    send_request(ACT_MEASURE, PIXEL_MAX, 1'b1);
    send_request(ACT_MEASURE, '0, 1'b0);
    send_request(ACT_NORMALIZE, '0, 1'b0);
    send_request(ACT_NORMALIZE, pixel_t'(1), 1'b0);
    send_request(ACT_NORMALIZE, pixel_t'(254), 1'b0);
    send_request(ACT_NORMALIZE, PIXEL_MAX, 1'b0);

    // random frames; idle pattern rotates every PHASE_ITEMS requests
    while (sent_count < 25 + RANDOM_ITEMS) begin
      case (((sent_count - 25) / PHASE_ITEMS) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      send_frame();
    end
    s_axis_tvalid = 1'b0;

    waited = 0;
    while (tracker.pending() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d scaled pixels never arrived", $time, tracker.pending());
      tracker.errors++;
    end

    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
